[hw/rtl/hncq_pkg.sv]
// ----------------------------------------------------------------------------
// hncq_pkg
// Shared types, constants and the HSV difference score function.
// ----------------------------------------------------------------------------
package hncq_pkg;

   localparam int MAX_CENTROIDS_DEF = 16;
   localparam int SCORE_W = 12;

   localparam logic [0:0] CMD_LOAD  = 1'b0;
   localparam logic [0:0] CMD_PIXEL = 1'b1;

   localparam logic [1:0] MODE_ORIG   = 2'd0;
   localparam logic [1:0] MODE_MOD    = 2'd1;
   localparam logic [1:0] MODE_COARSE = 2'd2;

   localparam logic [0:0] REG_MODE  = 1'b0;
   localparam logic [0:0] REG_COUNT = 1'b1;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] sat;
      logic [7:0] val;
   } hsv_type;

   function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
      absdiff = (a > b) ? (a - b) : (b - a);
   endfunction

   // Thresholded HSV difference; mode 3 acts as mode 0.
   function automatic logic [SCORE_W-1:0] score_of(input logic [1:0] mode,
                                                  input hsv_type c, input hsv_type p);
      logic [7:0] d, ds, dv, grey_lim, sat_lim, val_lim, fold;
      logic near_hue, md;
      d  = absdiff(c.hue, p.hue);
      ds = absdiff(c.sat, p.sat);
      dv = absdiff(c.val, p.val);
      md = (mode == MODE_MOD);
      grey_lim = 8'd30;
      sat_lim  = 8'd20;
      val_lim  = 8'd30;
      if (mode == MODE_COARSE) begin
         grey_lim = 8'd25;
         sat_lim  = 8'd40;
         val_lim  = 8'd127;
      end else if (md) begin
         grey_lim = 8'd50;
      end
      near_hue = (d < 8'd10) || (d > 8'd170);
      if (d < 8'd90)        fold = d;
      else if (d <= 8'd180) fold = 8'd180 - d;
      else                  fold = d - 8'd180;
      if (c.val < 8'd30 && p.val < 8'd30)
         score_of = '0;
      else if (c.sat < 8'd30 && p.sat < 8'd30 && dv < grey_lim)
         score_of = md ? {3'd0, dv, 1'b0} : '0;
      else if (near_hue && ds < sat_lim && dv < val_lim)
         score_of = md ? ({3'd0, ds, 1'b0} + {3'd0, dv, 1'b0}) : '0;
      else
         score_of = SCORE_W'(17 * int'(fold)) + {3'd0, ds, 1'b0} + {3'd0, dv, 1'b0};
   endfunction

endpackage

[hw/rtl/hsv_nearest_centroid_quantizer_unit.sv]
// ----------------------------------------------------------------------------
// hsv_nearest_centroid_quantizer_unit
// Nearest-centroid HSV quantizer: centroid table plus a compare pipeline.
// ----------------------------------------------------------------------------
// An accepted pixel passes through every compare stage register in turn before it is offered on rsp.
// Throughput: one pixel request per cycle while rsp is not stalled; one compare stage per table entry.
// A stall freezes the whole pipeline; a load waits until the pipeline is empty
// and leaves a one-cycle bubble behind it.
// Reset clears pipeline valid bits and sets mode 0, count 1; the table stays
// undefined until loaded.
module hsv_nearest_centroid_quantizer_unit #(
   parameter int MAX_CENTROIDS = hncq_pkg::MAX_CENTROIDS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic [3:0]                    req_slot,
   input  logic [7:0]                    req_hue,
   input  logic [7:0]                    req_saturation,
   input  logic [7:0]                    req_brightness,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [3:0]                    rsp_best_slot,
   output logic [7:0]                    rsp_best_hue,
   output logic [7:0]                    rsp_best_saturation,
   output logic [7:0]                    rsp_best_brightness,
   output logic [hncq_pkg::SCORE_W-1:0]  rsp_best_score,
   input  logic                          csr_write,
   input  logic                          csr_index,
   input  logic [4:0]                    csr_data
);
   import hncq_pkg::*;

   localparam int N     = MAX_CENTROIDS;
   localparam int IDX_W = (N > 1) ? $clog2(N) : 1;

   logic [1:0]       mode_ff;
   logic [4:0]       count_ff;
   hsv_type          table_ff [N];
   logic [IDX_W:0]   eff_count;

   logic             advance;
   logic             pipe_busy;
   logic             in_vld;
   hsv_type          pix;

   logic             vld_s   [N+1];
   logic [1:0]       mode_s  [N+1];
   logic [IDX_W:0]   cnt_s   [N+1];
   hsv_type          pix_s   [N+1];
   logic [IDX_W-1:0] bidx_s  [N+1];
   hsv_type          bent_s  [N+1];
   logic [SCORE_W-1:0] bsc_s [N+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_ORIG;
         count_ff <= 5'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MODE:  mode_ff  <= csr_data[1:0];
            REG_COUNT: count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (count_ff == 5'd0)
         eff_count = (IDX_W+1)'(1);
      else if (32'(count_ff) > N)
         eff_count = (IDX_W+1)'(N);
      else
         eff_count = (IDX_W+1)'(count_ff);
   end

   always_comb begin
      pipe_busy = 1'b0;
      for (int i = 1; i <= N; i++)
         pipe_busy = pipe_busy || vld_s[i];
   end

   // Hold a load until every earlier pixel has read the whole table.
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance && (req_command == CMD_PIXEL || !pipe_busy);
   assign in_vld    = req_valid && req_ready && req_command == CMD_PIXEL;
   assign pix       = '{hue: req_hue, sat: req_saturation, val: req_brightness};

   always_ff @(posedge clock) begin
      if (req_valid && req_ready && req_command == CMD_LOAD && 32'(req_slot) < N)
         table_ff[IDX_W'(req_slot)] <= pix;
   end

   assign vld_s[0]  = in_vld;
   assign mode_s[0] = mode_ff;
   assign cnt_s[0]  = eff_count;
   assign pix_s[0]  = pix;
   assign bidx_s[0] = '0;
   assign bent_s[0] = pix;
   assign bsc_s[0]  = '1;

   for (genvar g = 0; g < N; g++) begin : g_stage
      hncq_stage #(.IDX(g), .IDX_W(IDX_W)) u_stage (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .vld_in      (vld_s[g]),
         .mode_in     (mode_s[g]),
         .count_in    (cnt_s[g]),
         .pix_in      (pix_s[g]),
         .ent_in      (table_ff[g]),
         .best_idx_in (bidx_s[g]),
         .best_ent_in (bent_s[g]),
         .best_sc_in  (bsc_s[g]),
         .first_in    (g == 0),
         .vld_ff      (vld_s[g+1]),
         .mode_ff     (mode_s[g+1]),
         .count_ff    (cnt_s[g+1]),
         .pix_ff      (pix_s[g+1]),
         .best_idx_ff (bidx_s[g+1]),
         .best_ent_ff (bent_s[g+1]),
         .best_sc_ff  (bsc_s[g+1])
      );
   end

   assign rsp_valid           = vld_s[N];
   assign rsp_best_slot       = 4'(bidx_s[N]);
   assign rsp_best_hue        = bent_s[N].hue;
   assign rsp_best_saturation = bent_s[N].sat;
   assign rsp_best_brightness = bent_s[N].val;
   assign rsp_best_score      = bsc_s[N];

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_best_score))
      else $error("result changed under stall");
   a_score_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_best_score <= SCORE_W'(2550) || rsp_best_hue > 8'd179)
      else $error("score out of range");
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_best_slot) < N)
      else $error("slot beyond table");
   a_load_drained: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == CMD_LOAD |-> !pipe_busy)
      else $error("load accepted with pixels in flight");

endmodule

[hw/rtl/hncq_stage.sv]
// ----------------------------------------------------------------------------
// hncq_stage
// One compare stage: scores the pixel against one fixed table entry and keeps
// the running best (strictly less wins, so the earliest entry holds ties).
// ----------------------------------------------------------------------------
module hncq_stage #(
   parameter int IDX   = 0,
   parameter int IDX_W = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          vld_in,
   input  logic [1:0]                    mode_in,
   input  logic [IDX_W:0]                count_in,
   input  hncq_pkg::hsv_type             pix_in,
   input  hncq_pkg::hsv_type             ent_in,
   input  logic [IDX_W-1:0]              best_idx_in,
   input  hncq_pkg::hsv_type             best_ent_in,
   input  logic [hncq_pkg::SCORE_W-1:0]  best_sc_in,
   input  logic                          first_in,
   output logic                          vld_ff,
   output logic [1:0]                    mode_ff,
   output logic [IDX_W:0]                count_ff,
   output hncq_pkg::hsv_type             pix_ff,
   output logic [IDX_W-1:0]              best_idx_ff,
   output hncq_pkg::hsv_type             best_ent_ff,
   output logic [hncq_pkg::SCORE_W-1:0]  best_sc_ff
);
   import hncq_pkg::*;

   logic [SCORE_W-1:0] sc_in;
   logic               take_in;

   always_comb begin
      sc_in   = score_of(mode_in, ent_in, pix_in);
      take_in = first_in || ((IDX_W+1)'(IDX) < count_in && sc_in < best_sc_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mode_ff     <= mode_in;
         count_ff    <= count_in;
         pix_ff      <= pix_in;
         best_idx_ff <= take_in ? IDX_W'(IDX) : best_idx_in;
         best_ent_ff <= take_in ? ent_in : best_ent_in;
         best_sc_ff  <= take_in ? sc_in : best_sc_in;
      end
   end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for hsv_nearest_centroid_quantizer_unit. Centroid loads and pixel
// requests are streamed through a bursty valid/ready driver. A behavioral
// predictor tracks the centroid table and the two registers and queues the
// expected nearest centroid for every accepted pixel. A monitor compares each
// response field by field under a randomly stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;
   import hncq_pkg::*;

   localparam int NUM_SLOTS    = 16;
   localparam int PIPE_DRAIN   = NUM_SLOTS + 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 900;

   typedef struct {
      logic       command;
      logic [3:0] slot;
      logic [7:0] hue;
      logic [7:0] sat;
      logic [7:0] val;
   } request_type;

   typedef struct {
      logic [3:0]  slot;
      logic [7:0]  hue;
      logic [7:0]  sat;
      logic [7:0]  val;
      logic [11:0] score;
   } nearest_type;

   logic clock, reset;
   logic req_valid, req_ready, req_command;
   logic [3:0] req_slot;
   logic [7:0] req_hue, req_saturation, req_brightness;
   logic rsp_valid, rsp_ready;
   logic [3:0] rsp_best_slot;
   logic [7:0] rsp_best_hue, rsp_best_saturation, rsp_best_brightness;
   logic [SCORE_W-1:0] rsp_best_score;
   logic csr_write, csr_index;
   logic [4:0] csr_data;

   hsv_nearest_centroid_quantizer_unit dut (.*);

   request_type pending_requests[$];
   nearest_type expected_nearest[$];
   request_type active_req;
   logic [23:0] centroid_shadow[NUM_SLOTS];
   logic [23:0] gen_centroids[NUM_SLOTS];
   logic [1:0]  cur_mode;
   logic [4:0]  cur_count;
   logic sender_hold;
   int gap_left, burst_left;
   int mismatch_count = 0;
   int stall_left, ready_pattern;
   int cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int hsv_difference(logic [1:0] mode, logic [23:0] c, logic [23:0] p);
      int d, ds, dv, grey_lim, sat_lim, val_lim, fold;
      int ch, cs, cv, ph, ps, pv;
      bit md;
      ch = c[23:16]; cs = c[15:8]; cv = c[7:0];
      ph = p[23:16]; ps = p[15:8]; pv = p[7:0];
      d  = (ch > ph) ? ch - ph : ph - ch;
      ds = (cs > ps) ? cs - ps : ps - cs;
      dv = (cv > pv) ? cv - pv : pv - cv;
      md = (mode == MODE_MOD);
      grey_lim = 30; sat_lim = 20; val_lim = 30;
      if (mode == MODE_COARSE) begin
         grey_lim = 25; sat_lim = 40; val_lim = 127;
      end else if (md) begin
         grey_lim = 50;
      end
      if (cv < 30 && pv < 30) return 0;
      if (cs < 30 && ps < 30 && dv < grey_lim) return md ? 2 * dv : 0;
      if ((d < 10 || d > 170) && ds < sat_lim && dv < val_lim)
         return md ? 2 * ds + 2 * dv : 0;
      if (d < 90) fold = d;
      else if (d <= 180) fold = 180 - d;
      else fold = d - 180;
      return 17 * fold + 2 * ds + 2 * dv;
   endfunction

   function automatic nearest_type classify_pixel(request_type r);
      nearest_type res;
      int n, sc, best, best_sc;
      n = cur_count;
      if (n < 1) n = 1;
      if (n > NUM_SLOTS) n = NUM_SLOTS;
      best = 0;
      best_sc = 32'h7fffffff;
      for (int i = 0; i < n; i++) begin
         sc = hsv_difference(cur_mode, centroid_shadow[i], {r.hue, r.sat, r.val});
         if (sc < best_sc) begin
            best_sc = sc;
            best = i;
         end
      end
      res.slot  = best[3:0];
      res.hue   = centroid_shadow[best][23:16];
      res.sat   = centroid_shadow[best][15:8];
      res.val   = centroid_shadow[best][7:0];
      res.score = best_sc[11:0];
      return res;
   endfunction

   task automatic push_load(int slot, int h, int s, int v);
      request_type r;
      r.command = CMD_LOAD; r.slot = 4'(slot); r.hue = 8'(h); r.sat = 8'(s); r.val = 8'(v);
      gen_centroids[slot] = {r.hue, r.sat, r.val};
      pending_requests.insert(pending_requests.size(), r);
   endtask

   task automatic push_pixel(int h, int s, int v);
      request_type r;
      r.command = CMD_PIXEL; r.slot = 4'($urandom_range(0, 15));
      r.hue = 8'(h); r.sat = 8'(s); r.val = 8'(v);
      pending_requests.insert(pending_requests.size(), r);
   endtask

   function automatic int near_value(int c, int span, int maxv);
      int x;
      x = c + $urandom_range(0, 2 * span) - span;
      if (x < 0) x = 0;
      if (x > maxv) x = maxv;
      return x;
   endfunction

   task automatic push_random_item();
      int k, sel;
      logic [23:0] b;
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
         if ($urandom_range(0, 1))
            push_load($urandom_range(0, 15), $urandom_range(0, 179),
                      $urandom_range(0, 255), $urandom_range(0, 255));
         else
            push_load($urandom_range(0, 15), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 255));
      end else if (sel < 65) begin
         // land close to a stored centroid to exercise the threshold tests
         k = $urandom_range(0, 15);
         b = gen_centroids[k];
         push_pixel(near_value(b[23:16], 12, ($urandom_range(0, 9) == 0) ? 255 : 179),
                    near_value(b[15:8], 45, 255), near_value(b[7:0], 60, 255));
      end else if (sel < 75) begin
         push_pixel($urandom_range(0, 179), $urandom_range(0, 40), $urandom_range(0, 255));
      end else if (sel < 80) begin
         push_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 40));
      end else begin
         push_pixel(($urandom_range(0, 9) == 0) ? $urandom_range(180, 255)
                                                : $urandom_range(0, 179),
                    $urandom_range(0, 255), $urandom_range(0, 255));
      end
   endtask

   task automatic wait_idle();
      while (pending_requests.size() != 0 || req_valid || expected_nearest.size() != 0)
         @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, int value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[4:0];
      if (idx == REG_MODE) cur_mode = value[1:0];
      else cur_count = value[4:0];
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_command <= CMD_LOAD;
         req_slot <= '0;
         req_hue <= '0;
         req_saturation <= '0;
         req_brightness <= '0;
         gap_left <= 0;
         burst_left <= 0;
      end else begin
         if (req_valid && req_ready) begin
            if (active_req.command == CMD_LOAD)
               centroid_shadow[active_req.slot] =
                  {active_req.hue, active_req.sat, active_req.val};
            else
               expected_nearest.insert(expected_nearest.size(),
                                       classify_pixel(active_req));
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0 && !sender_hold) begin
               active_req = pending_requests.pop_front();
               req_command    <= active_req.command;
               req_slot       <= active_req.slot;
               req_hue        <= active_req.hue;
               req_saturation <= active_req.sat;
               req_brightness <= active_req.val;
               req_valid <= 1'b1;
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 48);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: own stall pattern plus a periodic long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
         ready_pattern <= 0;
      end else begin
         if (cycle_count % 64 == 0) ready_pattern <= $urandom_range(0, 3);
         if (cycle_count % 5000 == 1500) begin
            stall_left <= 300;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            case (ready_pattern)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= ($urandom_range(0, 1) != 0);
               default: rsp_ready <= (cycle_count % 7 < 4);
            endcase
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      nearest_type exp_n;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_nearest.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: slot %0d score %0d",
                        rsp_best_slot, rsp_best_score);
         end else begin
            exp_n = expected_nearest.pop_front();
            if (rsp_best_slot !== exp_n.slot || rsp_best_hue !== exp_n.hue ||
                rsp_best_saturation !== exp_n.sat ||
                rsp_best_brightness !== exp_n.val || rsp_best_score !== exp_n.score) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp slot %0d hsv %0d/%0d/%0d score %0d,",
                           exp_n.slot, exp_n.hue, exp_n.sat, exp_n.val, exp_n.score,
                           " got slot %0d hsv %0d/%0d/%0d score %0d",
                           rsp_best_slot, rsp_best_hue, rsp_best_saturation,
                           rsp_best_brightness, rsp_best_score);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      int modes[8];
      int counts[8];
      sender_hold = 1'b0;
      reset = 1'b1;
      csr_write = 1'b0; csr_index = REG_MODE; csr_data = '0;
      cur_mode = MODE_ORIG;
      cur_count = 5'd1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: fill the whole table with extreme and special colors
      push_load(0, 0, 0, 0);
      push_load(1, 179, 255, 255);
      push_load(2, 90, 128, 128);
      push_load(3, 5, 200, 200);
      push_load(4, 175, 200, 200);
      push_load(5, 60, 10, 100);
      push_load(6, 120, 255, 20);
      push_load(7, 30, 100, 250);
      for (int i = 8; i < NUM_SLOTS; i++)
         push_load(i, i * 11, i * 15, 255 - i * 9);
      wait_idle();
      write_csr(REG_COUNT, 16);
      push_pixel(0, 0, 0);          // dark pair
      push_pixel(179, 255, 255);
      push_pixel(60, 20, 120);      // grey pair
      push_pixel(178, 205, 210);    // hue wraps across zero
      push_pixel(8, 190, 210);      // near hue
      push_pixel(255, 128, 128);    // hue beyond range, fold above 180
      push_pixel(90, 255, 0);
      push_pixel(45, 128, 255);
      wait_idle();

      modes  = '{0, 1, 2, 3, 1, 2, 0, 1};
      counts = '{16, 1, 0, 31, 8, 16, 3, 16};
      for (int ph = 0; ph < 8; ph++) begin
         write_csr(REG_MODE, modes[ph]);
         write_csr(REG_COUNT, counts[ph]);
         push_pixel(60, 20, 120);
         push_pixel(178, 205, 210);
         for (int i = 0; i < RANDOM_ITEMS / 8; i++) push_random_item();
         if (ph == 3) begin
            // stop sending until everything in flight has come back
            while (pending_requests.size() > 60) @(posedge clock);
            sender_hold = 1'b1;
            while (req_valid || expected_nearest.size() != 0) @(posedge clock);
            sender_hold = 1'b0;
         end
         wait_idle();
      end

      if (mismatch_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
